// ----- hw/rtl/lzss_ring_decompressor_defines.svh -----
// Assertion macros shared by the LZSS ring decompressor modules.
`ifndef LZSS_RING_DECOMPRESSOR_DEFINES_SVH
`define LZSS_RING_DECOMPRESSOR_DEFINES_SVH

// The condition holds at every clock edge outside reset.
`define LZRD_ASSERT_HOLDS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) else $error(msg);

// When the trigger holds, the consequence holds at the following edge.
`define LZRD_ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/lzrd_pkg.sv -----
// Shared types and constants of the LZSS ring decompressor.
package lzrd_pkg;

    // History ring geometry and start position of the write pointer.
    localparam int RING_DEPTH = 4096;
    localparam int RING_AW = $clog2(RING_DEPTH);
    localparam logic [RING_AW-1:0] START_POINTER = 12'hfee;

    // Longest copy a reference can ask for (length field plus three).
    localparam int MAX_COPY = 18;
    localparam int LEN_W = $clog2(MAX_COPY + 1);
    localparam logic [LEN_W-1:0] MIN_MATCH = 5'd3;

    // Depth of the command queue between the parser and the executor.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

    // Input item kinds carried on tuser.
    localparam logic IN_DATA = 1'b0;
    localparam logic IN_START = 1'b1;

    // Configuration register indexes.
    localparam logic REG_INVERT = 1'b0;
    localparam logic REG_OUT_LEN = 1'b1;

    // Commands passed from the parser to the executor.
    typedef enum logic [1:0] {
        CMD_LIT,
        CMD_COPY,
        CMD_CLEAR
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind             kind;
        logic [7:0]            lit;
        logic [RING_AW-1:0]    pos;
        logic [LEN_W-1:0]      len;
        logic                  ends;
    } t_cmd;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

endpackage

// ----- hw/rtl/lzss_ring_decompressor.sv -----
// Top level of the LZSS ring decompressor: configuration port and stream channels.
//
// Usage: compressed bytes enter on the slave stream, one item per byte; tuser set
// to one marks a start command, which begins a new stream and clears the ring.
// Decompressed bytes leave on the master stream, one item per byte, with tlast
// on the byte that completes the configured output length.
// invert_input (address 0) and output_length (address 4) are to be written over
// the APB port while the block is idle; the block itself does not enforce this;
// a stream stops producing bytes at that length. A literal passes through the
// command queue and the executor into the output register. A reference starts
// with a ring read and then gives one byte per cycle, up to 18 bytes, while the
// output register is free; the 4096-byte history ring has a single read port.
// A start command makes the executor sweep all 4096 ring entries, while the
// parser keeps accepting items into a four-entry command queue.
// After reset the same sweep runs and s_tready stays low until it ends.
// When the receiver stalls, bytes wait in the output register and the queue,
// and s_tready falls once the queue is full.
module lzss_ring_decompressor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Compressed input.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_byte
    input  logic        s_tuser,    // [0] cmd
    // Decompressed output.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] out_byte
    output logic        m_tlast,
    // Configuration.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic        r_invert;
    logic [31:0] r_out_len;

    logic                  w_push;
    logic                  w_pop;
    logic                  w_init_busy;
    lzrd_pkg::t_cmd        w_push_cmd;
    lzrd_pkg::t_cmd        w_q_cmd;
    lzrd_pkg::t_queue_stat w_q_stat;
    logic                  w_reg;

    // Register file access.
    assign pready = 1'b1;
    assign w_reg = paddr[2];
    assign prdata = (w_reg == lzrd_pkg::REG_OUT_LEN) ? r_out_len : {31'b0, r_invert};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invert <= 1'b0;
            r_out_len <= '0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (w_reg)
                lzrd_pkg::REG_INVERT:  r_invert <= pwdata[0];
                lzrd_pkg::REG_OUT_LEN: r_out_len <= pwdata;
                default:               r_invert <= r_invert;
            endcase
        end
    end

    // Parser.
    lzrd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_tvalid),
        .o_ready     (s_tready),
        .i_cmd       (s_tuser),
        .i_byte      (s_tdata),
        .i_invert    (r_invert),
        .i_out_len   (r_out_len),
        .i_q_stat    (w_q_stat),
        .i_init_busy (w_init_busy),
        .o_push      (w_push),
        .o_cmd       (w_push_cmd)
    );

    // Command queue.
    lzrd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_q_cmd),
        .o_stat  (w_q_stat)
    );

    // Executor and history ring.
    lzrd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_cmd     (w_q_cmd),
        .i_q_stat    (w_q_stat),
        .o_pop       (w_pop),
        .o_init_busy (w_init_busy),
        .o_valid     (m_tvalid),
        .i_ready     (m_tready),
        .o_byte      (m_tdata),
        .o_last      (m_tlast)
    );

endmodule

// ----- hw/rtl/lzrd_front.sv -----
// Parser: accepts compressed items, tracks flags and turns tokens into commands.
module lzrd_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic                   i_cmd,
    input  logic [7:0]             i_byte,
    input  logic                   i_invert,
    input  logic [31:0]            i_out_len,
    input  lzrd_pkg::t_queue_stat  i_q_stat,
    input  logic                   i_init_busy,
    output logic                   o_push,
    output lzrd_pkg::t_cmd         o_cmd
);

    logic [7:0]  r_flag_bits, n_flag_bits;
    logic [3:0]  r_flags_left, n_flags_left;
    logic        r_phase, n_phase;
    logic [7:0]  r_ref_low, n_ref_low;
    logic [31:0] r_issued, n_issued;
    logic        r_done, n_done;

    logic                      w_acc;
    logic [7:0]                w_b;
    logic [31:0]               w_remain;
    logic [lzrd_pkg::LEN_W-1:0] w_len;
    logic [lzrd_pkg::LEN_W-1:0] w_eff;
    logic                      w_finished;

    // Items are taken while the queue has room and the ring is not being initialised.
    assign o_ready = !i_q_stat.full && !i_init_busy;
    assign w_acc = i_valid && o_ready;

    assign w_b = i_invert ? ~i_byte : i_byte;
    assign w_remain = i_out_len - r_issued;
    assign w_len = {1'b0, r_ref_low[3:0]} + lzrd_pkg::MIN_MATCH;
    assign w_eff = (w_remain < {27'b0, w_len}) ? w_remain[lzrd_pkg::LEN_W-1:0] : w_len;
    assign w_finished = r_done || (r_issued >= i_out_len);

    // Parse one item and decide which command, if any, it produces.
    always_comb begin
        n_flag_bits = r_flag_bits;
        n_flags_left = r_flags_left;
        n_phase = r_phase;
        n_ref_low = r_ref_low;
        n_issued = r_issued;
        n_done = r_done;
        o_push = 1'b0;
        o_cmd.kind = lzrd_pkg::CMD_LIT;
        o_cmd.lit = w_b;
        o_cmd.pos = {w_b, r_ref_low[7:4]};
        o_cmd.len = w_eff;
        o_cmd.ends = 1'b0;
        if (w_acc) begin
            priority if (i_cmd == lzrd_pkg::IN_START) begin
                n_flag_bits = '0;
                n_flags_left = '0;
                n_phase = 1'b0;
                n_ref_low = '0;
                n_issued = '0;
                n_done = 1'b0;
                o_push = 1'b1;
                o_cmd.kind = lzrd_pkg::CMD_CLEAR;
            end else if (w_finished) begin
                // Stream complete: data bytes are dropped.
            end else if (r_phase) begin
                // High byte of a reference: issue the copy, clipped at the length.
                n_phase = 1'b0;
                o_push = 1'b1;
                o_cmd.kind = lzrd_pkg::CMD_COPY;
                o_cmd.ends = (w_remain <= {27'b0, w_len});
                n_issued = r_issued + {27'b0, w_eff};
                n_done = r_done || o_cmd.ends;
                n_flag_bits = {r_flag_bits[6:0], 1'b0};
                if (r_flags_left != '0) begin
                    n_flags_left = r_flags_left - 4'd1;
                end
            end else if (r_flags_left == '0) begin
                n_flag_bits = w_b;
                n_flags_left = 4'd8;
            end else if (r_flag_bits[7]) begin
                o_push = 1'b1;
                o_cmd.kind = lzrd_pkg::CMD_LIT;
                o_cmd.ends = (w_remain == 32'd1);
                o_cmd.len = 5'd1;
                n_issued = r_issued + 32'd1;
                n_done = r_done || o_cmd.ends;
                n_flag_bits = {r_flag_bits[6:0], 1'b0};
                n_flags_left = r_flags_left - 4'd1;
            end else begin
                n_ref_low = w_b;
                n_phase = 1'b1;
            end
        end
    end

    // Parser state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag_bits <= '0;
            r_flags_left <= '0;
            r_phase <= 1'b0;
            r_ref_low <= '0;
            r_issued <= '0;
            r_done <= 1'b0;
        end else begin
            r_flag_bits <= n_flag_bits;
            r_flags_left <= n_flags_left;
            r_phase <= n_phase;
            r_ref_low <= n_ref_low;
            r_issued <= n_issued;
            r_done <= n_done;
        end
    end

endmodule

// ----- hw/rtl/lzrd_queue.sv -----
// Short command queue between the parser and the executor.
module lzrd_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  lzrd_pkg::t_cmd         i_cmd,
    input  logic                   i_pop,
    output lzrd_pkg::t_cmd         o_cmd,
    output lzrd_pkg::t_queue_stat  o_stat
);

    lzrd_pkg::t_cmd                r_mem [lzrd_pkg::QUEUE_DEPTH];
    logic [lzrd_pkg::QUEUE_AW-1:0] r_wr_ptr;
    logic [lzrd_pkg::QUEUE_AW-1:0] r_rd_ptr;
    logic [lzrd_pkg::QUEUE_CW-1:0] r_count;

    assign o_stat.full = (r_count == lzrd_pkg::QUEUE_CW'(lzrd_pkg::QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_cmd = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- hw/rtl/lzrd_back.sv -----
// Executor: runs commands against the history ring and drives the output register.
`include "lzss_ring_decompressor_defines.svh"

module lzrd_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  lzrd_pkg::t_cmd         i_q_cmd,
    input  lzrd_pkg::t_queue_stat  i_q_stat,
    output logic                   o_pop,
    output logic                   o_init_busy,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [7:0]             o_byte,
    output logic                   o_last
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LIT,
        ST_COPY,
        ST_CLEAR
    } t_state;

    t_state                         r_state;
    logic [7:0]                     r_ring [lzrd_pkg::RING_DEPTH];
    logic [lzrd_pkg::RING_AW-1:0]   r_wp;
    logic [lzrd_pkg::RING_AW-1:0]   r_rd_addr;
    logic [lzrd_pkg::RING_AW-1:0]   r_clr_addr;
    logic [lzrd_pkg::LEN_W-1:0]     r_left;
    logic [lzrd_pkg::LEN_W-1:0]     r_rd_left;
    logic                           r_pend;
    logic                           r_fwd;
    logic [7:0]                     r_fwd_data;
    logic [7:0]                     r_rd_data;
    logic [7:0]                     r_lit;
    logic                           r_ends;
    logic                           r_init;
    logic                           r_o_valid;
    logic [7:0]                     r_o_byte;
    logic                           r_o_last;

    logic                           w_free;
    logic                           w_emit_lit;
    logic                           w_emit_copy;
    logic                           w_emit;
    logic [7:0]                     w_byte;
    logic                           w_rd_en;
    logic                           w_we;
    logic [lzrd_pkg::RING_AW-1:0]   w_wa;
    logic [7:0]                     w_wd;

    // The output register can take a byte when empty or being drained.
    assign w_free = !r_o_valid || i_ready;
    assign w_emit_lit = (r_state == ST_LIT) && w_free;
    assign w_emit_copy = (r_state == ST_COPY) && r_pend && w_free;
    assign w_emit = w_emit_lit || w_emit_copy;

    // A read that hit the address written in the same cycle takes the forwarded byte.
    assign w_byte = (r_state == ST_LIT) ? r_lit : (r_fwd ? r_fwd_data : r_rd_data);

    // Reads run one ahead of emission while the read buffer can be freed.
    assign w_rd_en = (r_state == ST_COPY) && (r_rd_left != '0) && (!r_pend || w_free);

    // Ring write port: clearing sweep or the byte being emitted.
    assign w_we = (r_state == ST_CLEAR) || w_emit;
    assign w_wa = (r_state == ST_CLEAR) ? r_clr_addr : r_wp;
    assign w_wd = (r_state == ST_CLEAR) ? 8'h00 : w_byte;

    assign o_pop = (r_state == ST_IDLE) && !i_q_stat.empty;
    assign o_init_busy = r_init;
    assign o_valid = r_o_valid;
    assign o_byte = r_o_byte;
    assign o_last = r_o_last;

    // History ring with one write and one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_ring[w_wa] <= w_wd;
        end
        if (w_rd_en) begin
            r_rd_data <= r_ring[r_rd_addr];
        end
    end

    // Command sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr_addr <= '0;
            r_init <= 1'b1;
            r_o_valid <= 1'b0;
            r_pend <= 1'b0;
            r_fwd <= 1'b0;
            r_wp <= lzrd_pkg::START_POINTER;
            r_left <= '0;
            r_rd_left <= '0;
        end else begin
            if (w_emit) begin
                r_o_valid <= 1'b1;
                r_o_byte <= w_byte;
                r_o_last <= r_ends && ((r_state == ST_LIT) || (r_left == 5'd1));
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        r_ends <= i_q_cmd.ends;
                        case (i_q_cmd.kind)
                            lzrd_pkg::CMD_LIT: begin
                                r_lit <= i_q_cmd.lit;
                                r_state <= ST_LIT;
                            end
                            lzrd_pkg::CMD_COPY: begin
                                r_rd_addr <= i_q_cmd.pos;
                                r_left <= i_q_cmd.len;
                                r_rd_left <= i_q_cmd.len;
                                r_pend <= 1'b0;
                                r_fwd <= 1'b0;
                                r_state <= ST_COPY;
                            end
                            lzrd_pkg::CMD_CLEAR: begin
                                r_clr_addr <= '0;
                                r_state <= ST_CLEAR;
                            end
                            default: begin
                                r_state <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_LIT: begin
                    if (w_emit) begin
                        r_wp <= r_wp + 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                ST_COPY: begin
                    if (w_rd_en) begin
                        r_rd_addr <= r_rd_addr + 1'b1;
                        r_rd_left <= r_rd_left - 5'd1;
                        r_fwd <= w_emit && (r_rd_addr == r_wp);
                        r_fwd_data <= w_byte;
                        r_pend <= 1'b1;
                    end else if (w_emit) begin
                        r_pend <= 1'b0;
                    end
                    if (w_emit) begin
                        r_wp <= r_wp + 1'b1;
                        r_left <= r_left - 5'd1;
                        if (r_left == 5'd1) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == '1) begin
                        r_wp <= lzrd_pkg::START_POINTER;
                        r_init <= 1'b0;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Reads issued, reads buffered and bytes still owed must agree during a copy.
    `LZRD_ASSERT_HOLDS(a_copy_count, i_clk, i_rst_n,
        (r_state != ST_COPY) || (r_left == r_rd_left + {4'b0, r_pend}),
        "copy read and emit counts disagree")
    // A running copy always owes between one and the longest match of bytes.
    `LZRD_ASSERT_HOLDS(a_copy_len, i_clk, i_rst_n,
        (r_state != ST_COPY) || ((r_left != '0) && (r_left <= 5'd18)),
        "copy length out of range")
    // The end of a clearing sweep leaves the write pointer at its start position.
    `LZRD_ASSERT_NEXT(a_clear_end, i_clk, i_rst_n,
        (r_state == ST_CLEAR) && (r_clr_addr == '1),
        (r_state == ST_IDLE) && (r_wp == lzrd_pkg::START_POINTER) && !r_init,
        "clearing sweep did not finish cleanly")

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench of the LZSS ring decompressor, with its own decoder model.
module tb_top;

    // Expected output item: one decompressed byte and its end marker.
    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_decoded_byte;

    // Clock, reset and block ports.
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;              // [7:0] in_byte
    logic        s_tuser = lzrd_pkg::IN_DATA;  // [0] cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;                      // [7:0] out_byte
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // Decoder model state and its copy of the registers.
    logic [7:0]                   hist_ring [lzrd_pkg::RING_DEPTH];
    logic [lzrd_pkg::RING_AW-1:0] hist_wp;
    logic [7:0]                   flag_bits;
    logic [3:0]                   flags_left;
    logic                         ref_phase;
    logic [7:0]                   ref_low;
    logic [31:0]                  bytes_out;
    logic                         stream_done;
    logic                         cfg_invert = 1'b0;
    logic [31:0]                  cfg_out_len = 32'd0;

    // Bytes still to come from the block, oldest first.
    t_decoded_byte expected_bytes[$];

    int   mismatch_count = 0;
    int   random_items = 0;
    logic sweep_pending = 1'b1;
    logic tx_steady = 1'b0;
    logic rx_steady = 1'b0;
    logic rx_hold = 1'b0;
    event rx_hold_kick;

    lzss_ring_decompressor uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #2 i_clk = ~i_clk;

    // Run limit, far above the slowest correct run.
    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------

    // A new stream: empty history and fresh parse state.
    function automatic void clear_history();
        for (int i = 0; i < lzrd_pkg::RING_DEPTH; i++) hist_ring[i] = 8'h00;
        hist_wp = lzrd_pkg::START_POINTER;
        flag_bits = 8'h00;
        flags_left = 4'd0;
        ref_phase = 1'b0;
        ref_low = 8'h00;
        bytes_out = 32'd0;
        stream_done = 1'b0;
    endfunction

    // Every output byte also goes into the history ring.
    function automatic void emit_byte(input logic [7:0] b);
        t_decoded_byte item;
        hist_ring[hist_wp] = b;
        hist_wp = hist_wp + 1'b1;
        bytes_out = bytes_out + 1;
        item.data = b;
        item.last = (bytes_out == cfg_out_len);
        if (item.last) stream_done = 1'b1;
        expected_bytes.push_back(item);
    endfunction

    function automatic void take_flag();
        flag_bits = flag_bits << 1;
        if (flags_left != 4'd0) flags_left = flags_left - 1'b1;
    endfunction

    // Works out the bytes that one accepted input item releases.
    function automatic void decode_item(input logic cmd, input logic [7:0] data);
        logic [7:0]                   b;
        logic [15:0]                  word;
        logic [lzrd_pkg::RING_AW-1:0] pos;
        int                           len;
        if (cmd == lzrd_pkg::IN_START) begin
            clear_history();
            return;
        end
        if (stream_done || bytes_out >= cfg_out_len) return;
        b = cfg_invert ? ~data : data;
        if (ref_phase) begin
            word = {b, ref_low};
            len = word[3:0] + 3;
            pos = word[15:4];
            ref_phase = 1'b0;
            // Byte by byte, so an overlapping copy repeats what it has just written.
            for (int j = 0; j < len && bytes_out < cfg_out_len; j++) begin
                emit_byte(hist_ring[pos]);
                pos = pos + 1'b1;
            end
            take_flag();
            return;
        end
        if (flags_left == 4'd0) begin
            flag_bits = b;
            flags_left = 4'd8;
            return;
        end
        if (flag_bits[7]) begin
            emit_byte(b);
            take_flag();
            return;
        end
        ref_low = b;
        ref_phase = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offers one item, with random gaps, and records it once accepted.
    task automatic send_item(input logic cmd, input logic [7:0] data);
        while (!tx_steady && $urandom_range(99) < 34) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= data;
        do @(posedge i_clk); while (!s_tready);
        decode_item(cmd, data);
        if (cmd == lzrd_pkg::IN_START) sweep_pending = 1'b1;
    endtask

    // Sends a byte by its decoded meaning, complemented when invert mode is on.
    task automatic send_byte(input logic [7:0] b);
        send_item(lzrd_pkg::IN_DATA, b ^ {8{cfg_invert}});
    endtask

    task automatic send_ref(input logic [lzrd_pkg::RING_AW-1:0] pos, input logic [3:0] len_m3);
        logic [15:0] word;
        word = {pos, len_m3};
        send_byte(word[7:0]);
        send_byte(word[15:8]);
    endtask

    // Waits until all bytes are out and any ring sweep has surely ended.
    task automatic wait_idle();
        int settle;
        s_tvalid <= 1'b0;
        settle = sweep_pending ? 4300 : 40;
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
        sweep_pending = 1'b0;
    endtask

    // One register write; the port idles afterwards.
    task automatic write_reg(input logic idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        if (idx == lzrd_pkg::REG_INVERT) cfg_invert = value[0];
        else cfg_out_len = value;
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver side and result checking
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        m_tready <= !rx_hold && (rx_steady || $urandom_range(99) >= 34);
    end

    // Long receiver hold-off, counted here so the sender can keep offering items.
    initial begin
        forever begin
            @(rx_hold_kick);
            rx_hold <= 1'b1;
            repeat (400) @(posedge i_clk);
            rx_hold <= 1'b0;
        end
    end

    task automatic note_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("%s", msg);
    endtask

    always @(posedge i_clk) begin
        t_decoded_byte want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (expected_bytes.size() == 0) begin
                note_error($sformatf("unexpected output byte %02h last %b", m_tdata, m_tlast));
            end else begin
                want = expected_bytes.pop_front();
                if (m_tdata !== want.data || m_tlast !== want.last)
                    note_error($sformatf("output byte: expected %02h last %b, got %02h last %b",
                                         want.data, want.last, m_tdata, m_tlast));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Literal bytes at the extremes, no end in sight.
    task automatic test_literals();
        logic [7:0] lits [8];
        lits = '{8'h00, 8'hff, 8'h55, 8'haa, 8'h01, 8'h80, 8'h7f, 8'hfe};
        write_reg(lzrd_pkg::REG_INVERT, 32'd0);
        write_reg(lzrd_pkg::REG_OUT_LEN, 32'hffff_ffff);
        send_byte(8'hff);
        foreach (lits[i]) send_byte(lits[i]);
    endtask

    // References: overlapping copy, cleared area, ring wrap, start position.
    task automatic test_references();
        send_byte(8'hf0);
        send_byte(8'h11);
        send_byte(8'h22);
        send_byte(8'h33);
        send_byte(8'h44);
        send_ref(hist_wp - 1'b1, 4'hf);
        send_ref(12'h000, 4'h0);
        send_ref(12'hfff, 4'h2);
        send_ref(lzrd_pkg::START_POINTER, 4'h7);
    endtask

    // The receiver stalls for a long time while literals keep coming.
    task automatic test_output_stall();
        -> rx_hold_kick;
        repeat (4) begin
            send_byte(8'hff);
            repeat (8) send_byte(8'($urandom_range(255)));
        end
    endtask

    // A reference that runs past the end, then a byte after the end.
    task automatic test_cut_short();
        wait_idle();
        write_reg(lzrd_pkg::REG_OUT_LEN, bytes_out + 5);
        send_byte(8'h00);
        send_ref(hist_wp - 2'd3, 4'hf);
        send_byte(8'($urandom_range(255)));
    endtask

    // Lowering the length below the count ends the stream.
    task automatic test_length_lowered();
        wait_idle();
        write_reg(lzrd_pkg::REG_OUT_LEN, 32'd50);
        send_item(lzrd_pkg::IN_START, 8'h00);
        send_byte(8'hff);
        send_byte(8'h0f);
        send_byte(8'hf0);
        send_byte(8'h3c);
        wait_idle();
        write_reg(lzrd_pkg::REG_OUT_LEN, 32'd1);
        send_byte(8'hc3);
    endtask

    // Zero length ignores data; invert mode complements every byte.
    task automatic test_zero_length_invert();
        wait_idle();
        write_reg(lzrd_pkg::REG_INVERT, 32'd1);
        write_reg(lzrd_pkg::REG_OUT_LEN, 32'd0);
        send_item(lzrd_pkg::IN_START, 8'hff);
        send_byte(8'h5a);
        wait_idle();
        write_reg(lzrd_pkg::REG_OUT_LEN, 32'd12);
        send_byte(8'he0);
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(8'h12);
        send_ref(hist_wp - 2'd2, 4'h1);
    endtask

    // Mostly well-formed random token streams, with some stray bytes.
    task automatic run_random_stream(input int budget);
        int sent;
        sent = 0;
        while (!stream_done && sent < budget) begin
            if (ref_phase || $urandom_range(19) == 0) begin
                send_item(lzrd_pkg::IN_DATA, 8'($urandom_range(255)));
                sent++;
            end else if (flags_left == 4'd0) begin
                send_byte(8'($urandom_range(255)));
                sent++;
            end else if (flag_bits[7]) begin
                send_byte(8'($urandom_range(255)));
                sent++;
            end else begin
                if ($urandom_range(3) == 0)
                    send_ref(lzrd_pkg::RING_AW'($urandom_range(lzrd_pkg::RING_DEPTH - 1)),
                             4'($urandom_range(15)));
                else
                    send_ref(hist_wp - lzrd_pkg::RING_AW'($urandom_range(1, 40)),
                             4'($urandom_range(15)));
                sent += 2;
            end
        end
        random_items += sent;
        // A byte or two more, which the block ignores once the stream has ended.
        repeat ($urandom_range(1, 2)) send_item(lzrd_pkg::IN_DATA, 8'($urandom_range(255)));
    endtask

    task automatic test_random_streams();
        int stream_no;
        stream_no = 0;
        while (random_items < 50) begin
            wait_idle();
            write_reg(lzrd_pkg::REG_INVERT, $urandom_range(1));
            write_reg(lzrd_pkg::REG_OUT_LEN,
                      (stream_no == 3) ? 32'hffff_ffff : $urandom_range(20, 160));
            tx_steady <= (stream_no == 1);
            rx_steady <= (stream_no == 1);
            send_item(lzrd_pkg::IN_START, 8'($urandom_range(255)));
            run_random_stream(40);
            stream_no++;
        end
        tx_steady <= 1'b0;
        rx_steady <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        clear_history();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_literals();
        test_references();
        test_output_stall();
        test_cut_short();
        test_length_lowered();
        test_zero_length_invert();
        test_random_streams();
        s_tvalid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/lzrd_pkg.sv
hw/rtl/lzrd_front.sv
hw/rtl/lzrd_queue.sv
hw/rtl/lzrd_back.sv
hw/rtl/lzss_ring_decompressor.sv
tb/sv/tb_top.sv
